[src/mtx_pkg.sv]
package mtx_pkg;

	localparam int unsigned TBL_N   = 624;
	localparam int unsigned TBL_M   = 397;
	localparam int unsigned IDX_W   = $clog2(TBL_N);
	localparam int unsigned WORD_W  = 32;

	localparam logic [WORD_W-1:0] SEED_MULT   = 32'h6C07_8965;
	localparam logic [WORD_W-1:0] MATRIX_A    = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] UPPER_MASK  = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK  = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] TEMPER_B    = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] TEMPER_C    = 32'hEFC6_0000;
	localparam logic [WORD_W-1:0] SEED_RESET  = 32'd5489;

	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TBL_N - 1);
	localparam logic [IDX_W-1:0] IDX_FAR   = IDX_W'(TBL_M);
	localparam logic [IDX_W-1:0] IDX_WRAP  = IDX_W'(TBL_N - TBL_M);

	localparam logic OP_SEED = 1'b0;
	localparam logic OP_XOR  = 1'b1;

	typedef enum logic [1:0] {
		SD_IDLE,
		SD_MUL,
		SD_ADD
	} seed_state_t;

	// one write to the table
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [WORD_W-1:0] data;
	} tbl_wr_t;

	function automatic logic [WORD_W-1:0] twist_word(
		input logic [WORD_W-1:0] cur,
		input logic [WORD_W-1:0] nxt,
		input logic [WORD_W-1:0] far
	);
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] v;
		y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		v = far ^ (y >> 1);
		if (nxt[0]) begin
			v = v ^ MATRIX_A;
		end
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

[src/mtx_mem.sv]
module mtx_mem
	import mtx_pkg::*;
(
	input  logic              clk,
	input  tbl_wr_t           wr,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr_a,
	input  logic [IDX_W-1:0]  rd_addr_b,
	output logic [WORD_W-1:0] rd_data_a,
	output logic [WORD_W-1:0] rd_data_b
);

	logic [WORD_W-1:0] mem [TBL_N];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

[src/mtx_seeder.sv]
module mtx_seeder
	import mtx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] seed_value,
	output logic              busy,
	output tbl_wr_t           wr
);

	seed_state_t       st_q, st_d;
	logic [IDX_W-1:0]  sidx_q;
	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] sum;

	assign sum = prod_q + WORD_W'(sidx_q);

	always_comb begin
		st_d = st_q;
		case (st_q)
			SD_IDLE: if (start) st_d = SD_MUL;
			SD_MUL:  st_d = SD_ADD;
			SD_ADD:  st_d = (sidx_q == IDX_LAST) ? SD_IDLE : SD_MUL;
			default: st_d = SD_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		wr.en   = 1'b0;
		wr.addr = sidx_q;
		wr.data = sum;
		case (st_q)
			SD_IDLE: begin
				busy    = 1'b0;
				wr.en   = start;
				wr.addr = '0;
				wr.data = seed_value;
			end
			SD_MUL: ;
			SD_ADD: wr.en = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SD_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// entry i = mult * (p ^ (p >> 30)) + i, product registered before the add
	always_ff @(posedge clk) begin
		case (st_q)
			SD_IDLE: begin
				sidx_q <= IDX_W'(1);
				prev_q <= seed_value;
			end
			SD_MUL:  prod_q <= SEED_MULT * (prev_q ^ (prev_q >> 30));
			SD_ADD: begin
				prev_q <= sum;
				sidx_q <= sidx_q + IDX_W'(1);
			end
			default: ;
		endcase
	end

endmodule

[src/mtx_twister.sv]
module mtx_twister
	import mtx_pkg::*;
(
	input  logic [WORD_W-1:0] cur_word,
	input  logic [WORD_W-1:0] next_word,
	input  logic [WORD_W-1:0] far_word,
	input  logic [WORD_W-1:0] data,
	output logic [WORD_W-1:0] new_word,
	output logic [WORD_W-1:0] keystream
);

	assign new_word  = twist_word(cur_word, next_word, far_word);
	assign keystream = data ^ temper(new_word);

endmodule

[src/mt19937_keystream_xor.sv]
// Channel  Signals                                             Direction
// -------  --------------------------------------------------  ---------
// config   cfg_we, cfg_wdata (seed register, no wait)          in
// request  in_valid/in_ready: operation, data_in, last_in_buffer in
// result   out_valid/out_ready: keystream_out, last_out        out
//
// Word requests: one per cycle sustained while results are taken; each result passes
// through the table read stage, then the output register. Each word twists its
// table entry in place as it is read, so the two read ports and one write port of
// the table set the rate.
// Seed requests: one write of the seed, then a registered multiply and an add for
// each of the other 623 entries; no request is taken meanwhile.
// A seed request waits until the word in the read stage has written back.
// Reset clears control and sets the seed register to 5489; the table is undefined until seeded.
// A stalled result holds the read stage; nothing is dropped.
module mt19937_keystream_xor
	import mtx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [WORD_W-1:0] data_in,
	input  logic              last_in_buffer,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] keystream_out,
	output logic              last_out
);

	logic [WORD_W-1:0] seed_q;

	// word pipeline: read stage and output register
	logic              valid_s1;
	logic [WORD_W-1:0] data_s1;
	logic              last_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              out_valid_q;
	logic [WORD_W-1:0] keystream_q;
	logic              last_q;

	// next entry to hand out, and the current (old) value of that entry
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] cur_q;

	logic              seed_busy;
	tbl_wr_t           seed_wr;
	tbl_wr_t           tbl_wr;
	logic              accept;
	logic              seed_start;
	logic              word_take;
	logic              s1_adv;
	logic              s1_free;
	logic [IDX_W-1:0]  rd_addr_a;
	logic [IDX_W-1:0]  rd_addr_b;
	logic [WORD_W-1:0] rd_data_a;
	logic [WORD_W-1:0] rd_data_b;
	logic [WORD_W-1:0] new_word;
	logic [WORD_W-1:0] keystream;

	assign s1_adv  = valid_s1 && (!out_valid_q || out_ready);
	assign s1_free = !valid_s1 || s1_adv;

	// seed needs the write port to itself, so hold it until the read stage drains
	always_comb begin
		in_ready = 1'b0;
		if (!seed_busy) begin
			if (operation == OP_SEED) begin
				in_ready = !valid_s1;
			end else begin
				in_ready = s1_free;
			end
		end
	end

	assign accept     = in_valid && in_ready;
	assign seed_start = accept && (operation == OP_SEED);
	assign word_take  = accept && (operation == OP_XOR);

	// successor entry and the entry M ahead, both modulo the table size
	assign rd_addr_a = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
	assign rd_addr_b = (idx_q < IDX_WRAP) ? idx_q + IDX_FAR : idx_q - IDX_WRAP;

	always_comb begin
		tbl_wr = seed_wr;
		if (s1_adv) begin
			tbl_wr.en   = 1'b1;
			tbl_wr.addr = idx_s1;
			tbl_wr.data = new_word;
		end
	end

	mtx_seeder u_seeder (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (seed_start),
		.seed_value (seed_q),
		.busy       (seed_busy),
		.wr         (seed_wr)
	);

	mtx_mem u_mem (
		.clk       (clk),
		.wr        (tbl_wr),
		.rd_en     (word_take),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// entries below the current index already hold the new round, so the far
	// read picks up twisted values past the wrap exactly as an in-place twist does
	mtx_twister u_twister (
		.cur_word  (cur_q),
		.next_word (rd_data_a),
		.far_word  (rd_data_b),
		.data      (data_s1),
		.new_word  (new_word),
		.keystream (keystream)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (word_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (seed_start) begin
				idx_q <= '0;
			end else if (word_take) begin
				idx_q <= rd_addr_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (word_take) begin
			data_s1 <= data_in;
			last_s1 <= last_in_buffer;
			idx_s1  <= idx_q;
		end
		// entry 0 after a seed is the seed itself
		if (seed_start) begin
			cur_q <= seed_q;
		end else if (s1_adv) begin
			cur_q <= rd_data_a;
		end
		if (s1_adv) begin
			keystream_q <= keystream;
			last_q      <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign keystream_out = keystream_q;
	assign last_out      = last_q;

`ifndef SYNTHESIS
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(seed_wr.en && s1_adv))
		else $error("table written by seeder and word stage at once");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("table index past last entry");

	a_seed_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		seed_start |=> seed_busy && !in_ready)
		else $error("request taken while seeding");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		seed_busy |-> !valid_s1)
		else $error("word in read stage during seeding");
`endif

endmodule
